>>> rtl/core/pee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               underflow_seen;
    logic               overflow_seen;
    logic               div_zero_seen;
  } out_word_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [3:0] TEN      = 4'd10;

  // Datapath operations.
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       digit;      // accumulate a digit into the pending number
    logic       flush;      // push the pending number if there is one
    logic       pop_r;      // pop the right operand
    logic       pop_l;      // pop the left operand
    logic       pop_res;    // pop the final value into the output
    logic       start;      // start the arithmetic unit
    logic [2:0] op;
    logic       push_res;   // push the arithmetic result
    logic       clear;      // end of expression cleanup
    logic [3:0] digit_val;
  } cmd_t;

  typedef struct packed {
    logic busy;             // arithmetic unit still iterating
    logic mem_wait;         // a read of the stack is in flight
  } status_t;

endpackage
`default_nettype wire

>>> rtl/core/pee_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_datapath
// Operand stack, pending number, error flags and an iterative arithmetic unit
// for divide and power.
// ----------------------------------------------------------------------------
module pee_datapath #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pee_pkg::cmd_t   cmd,
  output pee_pkg::status_t     status,
  output logic [31:0]          result,
  output logic [2:0]           flags
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data;
  logic [CW-1:0] count;
  logic [31:0] pending;
  logic        pending_valid;
  logic [31:0] opr, opl;
  logic        rd_pend;
  logic        rd_to_l;
  logic        rd_to_res;
  logic        rd_empty;

  // Arithmetic unit state.
  logic        busy;
  logic [2:0]  op;
  logic [5:0]  step;
  logic [31:0] acc, aux, ex, quo, rem, dvs;
  logic        neg;
  logic [31:0] alu_res;

  logic [31:0] push_val;
  logic        push_en;
  logic        full;
  logic        empty;

  assign full  = (count == CW'(STACK_DEPTH));
  assign empty = (count == '0);

  // A stack push comes from either a flush or an arithmetic result.
  always_comb begin
    push_en  = 1'b0;
    push_val = alu_res;
    if (cmd.flush && pending_valid) begin
      push_en  = 1'b1;
      push_val = pending;
    end else if (cmd.push_res) begin
      push_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && !full) begin
      mem[count[AW-1:0]] <= push_val;
    end
    if ((cmd.pop_r || cmd.pop_l || cmd.pop_res) && !empty) begin
      rd_data <= mem[AW'(count - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      pending       <= '0;
      pending_valid <= 1'b0;
      flags         <= '0;
      rd_pend       <= 1'b0;
      busy          <= 1'b0;
    end else begin
      rd_pend <= cmd.pop_r || cmd.pop_l || cmd.pop_res;
      if (cmd.digit) begin
        pending       <= 32'(pending * 32'(pee_pkg::TEN)) + 32'(cmd.digit_val);
        pending_valid <= 1'b1;
      end
      if (push_en) begin
        if (full) begin
          flags[1] <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
        if (cmd.flush) begin
          pending       <= '0;
          pending_valid <= 1'b0;
        end
      end
      if (cmd.pop_r || cmd.pop_l || cmd.pop_res) begin
        rd_to_l   <= cmd.pop_l;
        rd_to_res <= cmd.pop_res;
        rd_empty  <= empty;
        if (empty) begin
          flags[0] <= 1'b1;
        end else begin
          count <= count - CW'(1);
        end
      end
      if (rd_pend) begin
        if (rd_to_res) begin
          result <= rd_empty ? 32'hFFFF_FFFF : rd_data;
        end else if (rd_to_l) begin
          opl <= rd_empty ? 32'hFFFF_FFFF : rd_data;
        end else begin
          opr <= rd_empty ? 32'hFFFF_FFFF : rd_data;
        end
      end
      if (cmd.clear) begin
        count         <= '0;
        pending       <= '0;
        pending_valid <= 1'b0;
        flags         <= '0;
      end
      // Arithmetic unit.
      if (cmd.start) begin
        op   <= cmd.op;
        step <= '0;
        // A zero divisor or a negative exponent gives its answer at once.
        busy <= ((cmd.op == pee_pkg::OP_DIV) && (opr != '0)) ||
                ((cmd.op == pee_pkg::OP_POW) && !opr[31]);
        neg  <= opl[31] ^ opr[31];
        acc  <= 32'd1;
        aux  <= opl;
        ex   <= opr;
        quo  <= opl[31] ? 32'(-opl) : opl;
        dvs  <= opr[31] ? 32'(-opr) : opr;
        rem  <= '0;
        unique case (cmd.op)
          pee_pkg::OP_ADD: alu_res <= opl + opr;
          pee_pkg::OP_SUB: alu_res <= opl - opr;
          pee_pkg::OP_MUL: alu_res <= 32'(opl * opr);
          pee_pkg::OP_POW: begin
            if (opr[31] && opl == 32'd1) begin
              alu_res <= 32'd1;
            end else if (opr[31] && opl == 32'hFFFF_FFFF) begin
              alu_res <= opr[0] ? 32'hFFFF_FFFF : 32'd1;
            end else begin
              alu_res <= '0;
            end
          end
          default:         alu_res <= '0;
        endcase
        if (cmd.op == pee_pkg::OP_DIV && opr == '0) begin
          flags[2] <= 1'b1;
        end
      end else if (busy) begin
        step <= step + 6'd1;
        if (op == pee_pkg::OP_DIV) begin
          // One restoring step per cycle, most significant bit first.
          logic [32:0] trial;
          trial = {rem, quo[31]} - {1'b0, dvs};
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
          if (step == 6'd31) begin
            busy    <= 1'b0;
            alu_res <= trial[32] ? (neg ? 32'(-{quo[30:0], 1'b0}) : {quo[30:0], 1'b0})
                                 : (neg ? 32'(-{quo[30:0], 1'b1}) : {quo[30:0], 1'b1});
          end
        end else begin
          // Square and multiply: one exponent bit per cycle.
          if (ex == '0) begin
            busy    <= 1'b0;
            alu_res <= acc;
          end else begin
            if (ex[0]) begin
              acc <= 32'(acc * aux);
            end
            aux <= 32'(aux * aux);
            ex  <= ex >> 1;
          end
        end
      end
    end
  end

  assign status.busy     = busy;
  assign status.mem_wait = rd_pend;

endmodule
`default_nettype wire

>>> rtl/core/pee_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pee_control
// Sequencer that turns each input word into datapath commands and holds the
// result word for the output channel.
// ----------------------------------------------------------------------------
module pee_control (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pee_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pee_pkg::out_word_t     out_data,
  output pee_pkg::cmd_t          cmd,
  input  wire pee_pkg::status_t  status,
  input  wire logic [31:0]       result,
  input  wire logic [2:0]        flags
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POPR  = 4'd1;
  localparam logic [3:0] S_POPL  = 4'd2;
  localparam logic [3:0] S_WAITL = 4'd3;
  localparam logic [3:0] S_START = 4'd4;
  localparam logic [3:0] S_RUN   = 4'd5;
  localparam logic [3:0] S_PUSH  = 4'd6;
  localparam logic [3:0] S_ENDP  = 4'd7;
  localparam logic [3:0] S_ENDW  = 4'd8;
  localparam logic [3:0] S_ENDO  = 4'd9;

  logic [3:0] state, state_next;
  logic [2:0] op, op_next;
  logic       accept;
  logic       out_free;
  logic       is_digit, is_op;
  logic [2:0] dec_op;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign is_digit = (in_data.char_code >= pee_pkg::CH_ZERO) &&
                    (in_data.char_code <= pee_pkg::CH_NINE);

  always_comb begin
    is_op  = 1'b1;
    dec_op = pee_pkg::OP_ADD;
    unique case (in_data.char_code)
      pee_pkg::CH_PLUS:  dec_op = pee_pkg::OP_ADD;
      pee_pkg::CH_MINUS: dec_op = pee_pkg::OP_SUB;
      pee_pkg::CH_MUL:   dec_op = pee_pkg::OP_MUL;
      pee_pkg::CH_DIV:   dec_op = pee_pkg::OP_DIV;
      pee_pkg::CH_POW:   dec_op = pee_pkg::OP_POW;
      default:           is_op  = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.kind) begin
            cmd.flush  = 1'b1;
            state_next = S_ENDP;
          end else if (is_digit) begin
            cmd.digit     = 1'b1;
            cmd.digit_val = 4'(in_data.char_code - pee_pkg::CH_ZERO);
          end else begin
            cmd.flush = 1'b1;
            if (is_op) begin
              op_next    = dec_op;
              state_next = S_POPR;
            end
          end
        end
      end
      S_POPR: begin
        cmd.pop_r  = 1'b1;
        state_next = S_POPL;
      end
      S_POPL: begin
        cmd.pop_l  = 1'b1;
        state_next = S_WAITL;
      end
      S_WAITL: state_next = S_START;
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (!status.busy) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_next   = S_IDLE;
      end
      S_ENDP: begin
        cmd.pop_res = 1'b1;
        state_next  = S_ENDW;
      end
      S_ENDW: state_next = S_ENDO;
      S_ENDO: begin
        // Hold here until the output register can take the result word.
        if (out_free) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= pee_pkg::OP_ADD;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (state == S_ENDO && out_free) begin
        out_valid               <= 1'b1;
        out_data.result_value   <= result;
        out_data.underflow_seen <= flags[0];
        out_data.overflow_seen  <= flags[1];
        out_data.div_zero_seen  <= flags[2];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/postfix_expression_evaluator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Evaluates a postfix expression fed one character per input word.
// ----------------------------------------------------------------------------
// Usage: in_valid/in_ready carry one character word (kind, char_code); a word
// with kind set ends the expression. out_valid/out_ready carry one result word
// per end word: the popped value and the sticky error flags.
// Timing: a digit or other character is handled as it is taken. A flush push
// happens in the same cycle. An operator for + - * runs through two stack reads
// through the registered memory port, start and push; / adds 32 restoring steps
// and ^ adds one exponent bit per cycle, up to 32 passes. An end word pops the
// stack through the registered port before the result word is shown.
// Reset empties the stack, clears the pending number and flags and the output
// register. While the receiver stalls, the result word is held and the words
// of the next expression are still taken; its end word then waits, with the
// input stalled, until the output register is free.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pee_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pee_pkg::out_word_t      out_data
);

  pee_pkg::cmd_t    cmd;
  pee_pkg::status_t status;
  logic [31:0]      result;
  logic [2:0]       flags;

  pee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .result(result), .flags(flags)
  );

  pee_control u_ctl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cmd(cmd), .status(status), .result(result), .flags(flags)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && cmd.push_res)) else $error("start and push together");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !in_ready) else $error("input taken while unit busy");
  a_no_accept_read: assert property (@(posedge clk) disable iff (rst)
    status.mem_wait |-> !in_ready) else $error("input taken during stack read");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result word lost");

endmodule
`default_nettype wire

>>> tb/postfix_expression_evaluator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_checker
// Watches both channels of the evaluator, keeps its own copy of the operand
// stack, works out the result word of each end word and compares it.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire pee_pkg::in_word_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire pee_pkg::out_word_t out_data,
  output int                      fail_count,
  output int                      pending_results
);

  logic [31:0]        opnd_stack [STACK_DEPTH];
  int                 opnd_count;
  logic [31:0]        num_acc;
  logic               num_live;
  logic               flag_under, flag_over, flag_divz;
  pee_pkg::out_word_t result_fifo [$];

  assign pending_results = result_fifo.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result mismatch on %s: got %0h, expected %0h", $realtime, what, got,
             want);
    fail_count++;
  endtask

  function automatic void push_opnd(input logic [31:0] v);
    if (opnd_count >= STACK_DEPTH) begin
      flag_over = 1'b1;
    end else begin
      opnd_stack[opnd_count] = v;
      opnd_count++;
    end
  endfunction

  function automatic logic [31:0] pop_opnd();
    if (opnd_count == 0) begin
      flag_under = 1'b1;
      return 32'hFFFF_FFFF;
    end
    opnd_count--;
    return opnd_stack[opnd_count];
  endfunction

  function automatic void flush_number();
    if (num_live) begin
      push_opnd(num_acc);
      num_acc  = '0;
      num_live = 1'b0;
    end
  endfunction

  function automatic logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (b == 0) begin
      flag_divz = 1'b1;
      return '0;
    end
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] power(input logic [31:0] base, input logic [31:0] ex);
    logic [31:0] acc;
    acc = 32'd1;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      return '0;
    end
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      base = base * base;
      ex   = ex >> 1;
    end
    return acc;
  endfunction

  task automatic evaluate_word(input pee_pkg::in_word_t w);
    logic [31:0]        r, l, v;
    pee_pkg::out_word_t res;
    if (w.kind) begin
      flush_number();
      r = pop_opnd();
      res.result_value   = r;
      res.underflow_seen = flag_under;
      res.overflow_seen  = flag_over;
      res.div_zero_seen  = flag_divz;
      result_fifo = {result_fifo, res};
      opnd_count = 0;
      num_acc    = '0;
      num_live   = 1'b0;
      {flag_under, flag_over, flag_divz} = '0;
    end else if (w.char_code >= pee_pkg::CH_ZERO && w.char_code <= pee_pkg::CH_NINE) begin
      num_acc  = num_acc * pee_pkg::TEN + 32'(w.char_code - pee_pkg::CH_ZERO);
      num_live = 1'b1;
    end else begin
      flush_number();
      if (w.char_code inside {pee_pkg::CH_PLUS, pee_pkg::CH_MINUS, pee_pkg::CH_MUL,
                              pee_pkg::CH_DIV, pee_pkg::CH_POW}) begin
        r = pop_opnd();
        l = pop_opnd();
        case (w.char_code)
          pee_pkg::CH_PLUS:  v = l + r;
          pee_pkg::CH_MINUS: v = l - r;
          pee_pkg::CH_MUL:   v = l * r;
          pee_pkg::CH_DIV:   v = quotient(l, r);
          default:           v = power(l, r);
        endcase
        push_opnd(v);
      end
    end
  endtask

  always @(posedge clk) begin
    pee_pkg::out_word_t want;
    if (rst) begin
      opnd_count = 0;
      num_acc    = '0;
      num_live   = 1'b0;
      {flag_under, flag_over, flag_divz} = '0;
      result_fifo.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("unexpected word", 32'(out_data.result_value), '0);
        end else begin
          want = result_fifo.pop_front();
          if (out_data.result_value !== want.result_value)
            report_mismatch("result_value", out_data.result_value, want.result_value);
          if (out_data.underflow_seen !== want.underflow_seen)
            report_mismatch("underflow_seen", 32'(out_data.underflow_seen),
                            32'(want.underflow_seen));
          if (out_data.overflow_seen !== want.overflow_seen)
            report_mismatch("overflow_seen", 32'(out_data.overflow_seen),
                            32'(want.overflow_seen));
          if (out_data.div_zero_seen !== want.div_zero_seen)
            report_mismatch("div_zero_seen", 32'(out_data.div_zero_seen),
                            32'(want.div_zero_seen));
        end
      end
      if (in_valid && in_ready) evaluate_word(in_data);
    end
  end

endmodule

>>> tb/postfix_expression_evaluator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top_tb
// Feeds directed and random postfix expressions to the evaluator under
// shifting idle patterns and back-pressure; the checker grades every result.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top_tb;

  localparam int DEPTH     = 64;
  localparam int MAX_CYCLE = 600000;
  localparam int HOLD_LEN  = 400;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  pee_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  pee_pkg::out_word_t out_data;
  int                 fail_count;
  int                 pending_results;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 hold_req = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int                 cycle_count = 0;
  int                 words_sent;

  postfix_expression_evaluator_top #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  postfix_expression_evaluator_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("postfix_expression_evaluator_top_tb: FAIL");
      $finish;
    end
  end

  // The receiver; a long hold-off is started by a new request and counted
  // down here.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sends one character word, with a random gap ahead of it.
  task automatic send_word(input logic kind, input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.kind      <= kind;
    in_data.char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_word(1'b0, s[i]);
  endtask

  task automatic send_number(input logic [31:0] n);
    send_text($sformatf("%0d", n));
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(4))
      0:       return pee_pkg::CH_PLUS;
      1:       return pee_pkg::CH_MINUS;
      2:       return pee_pkg::CH_MUL;
      3:       return pee_pkg::CH_DIV;
      default: return pee_pkg::CH_POW;
    endcase
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0:       return 32'($urandom_range(9));
      1:       return 32'($urandom_range(99));
      2:       return 32'($urandom_range(40));
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // A well-formed expression, with the odd mistake thrown in.
  task automatic send_expression();
    int depth;
    int steps;
    depth = 0;
    steps = $urandom_range(1, 6);
    for (int i = 0; i < steps * 2; i++) begin
      if (depth >= 2 && ($urandom_range(1) == 1 || i >= steps)) begin
        send_word(1'b0, pick_operator());
        depth--;
      end else begin
        send_number(pick_operand());
        send_word(1'b0, ($urandom_range(7) == 0) ? 8'(" ") : pee_pkg::CH_COMMA);
        depth++;
      end
      if ($urandom_range(30) == 0) send_word(1'b0, 8'($urandom));
    end
    send_word(1'b1, 8'($urandom));
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 9;
    recv_idle_pct = 52;
    words_sent    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed expressions covering each operator and special case.
    send_text("12,34+");   send_word(1'b1, 8'h00);
    send_text("5,9-");     send_word(1'b1, 8'hFF);
    send_text("7,6*");     send_word(1'b1, 8'h00);
    send_text("7,0/");     send_word(1'b1, 8'h00);
    send_text("3,5^");     send_word(1'b1, 8'h00);
    send_text("+");        send_word(1'b1, 8'h00);
    send_word(1'b1, 8'h00);
    send_text("4294967295"); send_word(1'b1, 8'h00);
    send_text("2147483648,4294967295/"); send_word(1'b1, 8'h00);

    // Fill the stack past its depth while the receiver stops for a while.
    hold_req++;
    for (int i = 0; i < DEPTH + 2; i++) send_text("1,");
    send_word(1'b1, 8'h00);
    send_text("9,x");
    send_word(1'b1, 8'h00);
    in_valid <= 1'b0;
    wait (pending_results == 0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 9 : 0;
      for (int n = 0; n < 400 / 3; n++) begin
        if ($urandom_range(9) == 0) send_word(1'b0, 8'($urandom));
        else if (words_sent < 400 * (ph + 1)) send_expression();
      end
      send_word(1'b1, 8'h00);
    end
    in_valid <= 1'b0;

    wait (pending_results == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("postfix_expression_evaluator_top_tb: PASS");
    end else begin
      $display("postfix_expression_evaluator_top_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pee_pkg.sv
rtl/core/pee_datapath.sv
rtl/core/pee_control.sv
rtl/core/postfix_expression_evaluator_top.sv
tb/postfix_expression_evaluator_checker.sv
tb/postfix_expression_evaluator_top_tb.sv
